// File: hdl/gfmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfmd_pkg
// Types and constants shared by the gamepad frame motor decoder.
// ----------------------------------------------------------------------------
package gfmd_pkg;

   localparam logic [7:0] START_BYTE = 8'h80;
   localparam logic [7:0] Y_FWD      = 8'h00;
   localparam logic [7:0] Y_REV      = 8'h7f;
   localparam int unsigned BTN_CIRCLE_BIT = 6;
   localparam int unsigned BTN_CROSS_BIT  = 5;
   localparam logic [2:0] LAST_PAYLOAD_IDX = 3'd5;

   localparam int unsigned CSR_DATA_W = 10;
   localparam int unsigned CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LOW  = 2'd0,
      CSR_WINDOW_HIGH = 2'd1,
      CSR_DRIVE_DUTY  = 2'd2,
      CSR_CHECK_TRIES = 2'd3
   } csr_index_type;

   localparam logic [6:0] WINDOW_LOW_RST  = 7'd36;
   localparam logic [6:0] WINDOW_HIGH_RST = 7'd100;
   localparam logic [9:0] DRIVE_DUTY_RST  = 10'd512;
   localparam logic [3:0] CHECK_TRIES_RST = 4'd10;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_CHECK   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   typedef struct packed {
      logic [6:0] window_low;
      logic [6:0] window_high;
      logic [9:0] drive_duty;
      logic [3:0] checksum_tries;
   } cfg_type;

   typedef struct packed {
      dir_type    dir;
      logic [9:0] duty;
   } motor_type;

   typedef struct packed {
      logic       frame_ok;
      logic [1:0] motor_a_dir;
      logic [9:0] motor_a_duty;
      logic [1:0] motor_b_dir;
      logic [9:0] motor_b_duty;
   } rsp_type;

endpackage
`default_nettype wire

// File: hdl/gfmd_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfmd_ifs
// Request and response channel interfaces (valid/ready).
// ----------------------------------------------------------------------------
interface gfmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gfmd_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_ok;
   logic [1:0] motor_a_dir;
   logic [9:0] motor_a_duty;
   logic [1:0] motor_b_dir;
   logic [9:0] motor_b_duty;

   modport source (output valid, output frame_ok, output motor_a_dir, output motor_a_duty,
                   output motor_b_dir, output motor_b_duty, input ready);
   modport sink   (input valid, input frame_ok, input motor_a_dir, input motor_a_duty,
                   input motor_b_dir, input motor_b_duty, output ready);
endinterface
`default_nettype wire

// File: hdl/gfmd_csr_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfmd_csr_bank
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module gfmd_csr_bank (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [gfmd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gfmd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output gfmd_pkg::cfg_type                    cfg
);
   import gfmd_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_low     <= WINDOW_LOW_RST;
         cfg_ff.window_high    <= WINDOW_HIGH_RST;
         cfg_ff.drive_duty     <= DRIVE_DUTY_RST;
         cfg_ff.checksum_tries <= CHECK_TRIES_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_LOW:  cfg_ff.window_low     <= csr_wdata[6:0];
            CSR_WINDOW_HIGH: cfg_ff.window_high    <= csr_wdata[6:0];
            CSR_DRIVE_DUTY:  cfg_ff.drive_duty     <= csr_wdata[9:0];
            CSR_CHECK_TRIES: cfg_ff.checksum_tries <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: hdl/gfmd_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfmd_frame_parser
// Frame hunt, payload capture, checksum search and motor update, one byte
// per accepted request.
// ----------------------------------------------------------------------------
module gfmd_frame_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire gfmd_pkg::cfg_type cfg,
   input  wire logic       byte_valid,
   input  wire logic [7:0] rx_byte,
   output logic            evt_valid,
   output gfmd_pkg::rsp_type evt
);
   import gfmd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [2:0] idx_ff, idx_in;
   logic [6:0] sum_ff, sum_in;
   logic [3:0] mis_ff, mis_in;
   motor_type  motor_a_ff, motor_a_in;
   motor_type  motor_b_ff, motor_b_in;
   logic [7:0] fb_ff [1:5];

   logic [2:0] slot;
   logic [3:0] mis_inc;
   logic       is_start;
   logic       sum_match;
   logic       give_up;
   motor_type  stick_a;
   motor_type  stick_b;

   function automatic motor_type stick_drive(input logic [7:0] x, input logic [7:0] y,
                                             input cfg_type c);
      motor_type m;
      m.dir  = DIR_STOP;
      m.duty = '0;
      if ((x > {1'b0, c.window_low}) && (x < {1'b0, c.window_high})) begin
         if (y == Y_FWD) begin
            m.dir  = DIR_FWD;
            m.duty = c.drive_duty;
         end else if (y == Y_REV) begin
            m.dir  = DIR_REV;
            m.duty = c.drive_duty;
         end
      end
      return m;
   endfunction

   assign slot      = (idx_ff > LAST_PAYLOAD_IDX) ? LAST_PAYLOAD_IDX : idx_ff;
   assign mis_inc   = mis_ff + 4'd1;
   assign is_start  = (rx_byte == START_BYTE);
   assign sum_match = (rx_byte == {1'b0, sum_ff});
   assign give_up   = !sum_match && (mis_inc >= cfg.checksum_tries);
   assign stick_a   = stick_drive(fb_ff[4], fb_ff[5], cfg);
   assign stick_b   = stick_drive(fb_ff[2], fb_ff[3], cfg);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_PAYLOAD: if (slot == LAST_PAYLOAD_IDX) phase_in = PH_CHECK;
            PH_CHECK:   if (sum_match || give_up) phase_in = PH_HUNT;
            default:    phase_in = is_start ? PH_PAYLOAD : PH_HUNT;
         endcase
      end
   end

   // datapath and event outputs
   always_comb begin
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      mis_in     = mis_ff;
      motor_a_in = motor_a_ff;
      motor_b_in = motor_b_ff;
      evt_valid  = 1'b0;
      evt.frame_ok = 1'b0;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               idx_in = slot + 3'd1;
               sum_in = sum_ff + rx_byte[6:0];
               if (slot == LAST_PAYLOAD_IDX) mis_in = '0;
            end
            PH_CHECK: begin
               if (sum_match) begin
                  motor_a_in = stick_a;
                  motor_b_in = stick_b;
                  if (fb_ff[1][BTN_CIRCLE_BIT]) begin
                     motor_a_in = '{dir: DIR_REV, duty: cfg.drive_duty};
                     motor_b_in = '{dir: DIR_FWD, duty: cfg.drive_duty};
                  end
                  if (fb_ff[1][BTN_CROSS_BIT]) begin
                     motor_a_in = '{dir: DIR_FWD, duty: cfg.drive_duty};
                     motor_b_in = '{dir: DIR_REV, duty: cfg.drive_duty};
                  end
                  evt_valid    = 1'b1;
                  evt.frame_ok = 1'b1;
               end else if (give_up) begin
                  mis_in    = '0;
                  evt_valid = 1'b1;
               end else begin
                  mis_in = mis_inc;
               end
            end
            default: begin
               if (is_start) begin
                  idx_in = '0;
                  sum_in = '0;
               end
            end
         endcase
      end
      evt.motor_a_dir  = motor_a_in.dir;
      evt.motor_a_duty = motor_a_in.duty;
      evt.motor_b_dir  = motor_b_in.dir;
      evt.motor_b_duty = motor_b_in.duty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         idx_ff     <= '0;
         sum_ff     <= '0;
         mis_ff     <= '0;
         motor_a_ff <= '{dir: DIR_STOP, duty: '0};
         motor_b_ff <= '{dir: DIR_STOP, duty: '0};
      end else begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         sum_ff     <= sum_in;
         mis_ff     <= mis_in;
         motor_a_ff <= motor_a_in;
         motor_b_ff <= motor_b_in;
      end
   end

   // payload byte 0 is never read; keep 1..5
   always_ff @(posedge clock) begin
      if (byte_valid && (phase_ff == PH_PAYLOAD) && (slot != 3'd0)) begin
         fb_ff[slot] <= rx_byte;
      end
   end

endmodule
`default_nettype wire

// File: hdl/gfmd_rsp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfmd_rsp_queue
// Two-entry response buffer that decouples the parser from the response
// channel.
// ----------------------------------------------------------------------------
module gfmd_rsp_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire gfmd_pkg::rsp_type push_data,
   output logic             full,
   gfmd_rsp_if.source       rsp_bus
);
   import gfmd_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;
   rsp_type    head;

   assign pop   = rsp_bus.valid && rsp_bus.ready;
   assign wr_in = wr_ff ^ push;
   assign rd_in = rd_ff ^ pop;

   always_comb begin
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign head = slot_ff[rd_ff];
   assign full = cnt_ff[1];

   assign rsp_bus.valid        = (cnt_ff != 2'd0);
   assign rsp_bus.frame_ok     = head.frame_ok;
   assign rsp_bus.motor_a_dir  = head.motor_a_dir;
   assign rsp_bus.motor_a_duty = head.motor_a_duty;
   assign rsp_bus.motor_b_dir  = head.motor_b_dir;
   assign rsp_bus.motor_b_duty = head.motor_b_duty;

endmodule
`default_nettype wire

// File: hdl/gamepad_frame_motor_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_frame_motor_decoder_unit
// Gamepad frame decoder driving two motor channels from received bytes.
// ----------------------------------------------------------------------------
// Takes one received byte per request and answers each accepted or abandoned
// frame with one response carrying frame_ok and both motor settings. Every
// byte is handled in the cycle it is accepted, so a byte can be taken on
// every clock; the parser registers feed a two-entry response buffer, and
// req ready drops only while both buffer entries wait on the response side.
// A response is queued in the cycle after the byte that completes or abandons
// a frame, behind any waiting one. Configuration writes take effect on the
// next clock and belong only between frames.
module gamepad_frame_motor_decoder_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   gfmd_req_if.sink                             req_bus,
   gfmd_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_we,
   input  wire logic [gfmd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gfmd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gfmd_pkg::*;

   cfg_type cfg;
   rsp_type evt;
   logic    evt_valid;
   logic    q_full;
   logic    req_fire;

   assign req_bus.ready = !q_full;
   assign req_fire      = req_bus.valid && req_bus.ready;

   gfmd_csr_bank u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gfmd_frame_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .byte_valid (req_fire),
      .rx_byte    (req_bus.rx_byte),
      .evt_valid  (evt_valid),
      .evt        (evt)
   );

   gfmd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_valid),
      .push_data (evt),
      .full      (q_full),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire

// File: hdl/gfmd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfmd_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module gfmd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_frame_ok,
   input wire logic [1:0] rsp_motor_a_dir,
   input wire logic [9:0] rsp_motor_a_duty,
   input wire logic [1:0] rsp_motor_b_dir,
   input wire logic [9:0] rsp_motor_b_duty
);
   import gfmd_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_ok)
      && $stable(rsp_motor_a_duty) && $stable(rsp_motor_b_duty))
      else $error("stalled response changed");

   // back-pressure only while responses are pending
   a_stall_pending: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   a_clean_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   // a stopped motor never carries duty
   a_stop_no_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_motor_a_dir != DIR_STOP || rsp_motor_a_duty == '0)
      && (rsp_motor_b_dir != DIR_STOP || rsp_motor_b_duty == '0))
      else $error("stopped motor with nonzero duty");

   a_dir_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_motor_a_dir != 2'd3 && rsp_motor_b_dir != 2'd3)
      else $error("undefined motor direction");

endmodule

bind gamepad_frame_motor_decoder_unit gfmd_checker u_gfmd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_frame_ok     (rsp_bus.frame_ok),
   .rsp_motor_a_dir  (rsp_bus.motor_a_dir),
   .rsp_motor_a_duty (rsp_bus.motor_a_duty),
   .rsp_motor_b_dir  (rsp_bus.motor_b_dir),
   .rsp_motor_b_duty (rsp_bus.motor_b_duty)
);
`default_nettype wire
